@@ design/floppy_drive_control_sense_macros.svh @@
// ----------------------------------------------------------------------------
// Floppy drive control sense - assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef FLOPPY_DRIVE_CONTROL_SENSE_MACROS_SVH
`define FLOPPY_DRIVE_CONTROL_SENSE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FDCS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdcs check failed");

// next-cycle implication
`define FDCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdcs check failed");

`else

`define FDCS_ASSERT_NOW(name, clk, rst, ante, cons)
`define FDCS_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ design/fdcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Floppy drive control sense - package
// Item layouts, widths and selector codes shared by the block's modules.
// ----------------------------------------------------------------------------
package fdcs_pkg;

   localparam int LINES_W     = 5;
   localparam int TRACK_W     = 7;
   localparam int ZONE_W      = 3;
   localparam int SEL_W       = 4;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam logic [ZONE_W-1:0] ZONE_MAX = 3'd4;

   typedef logic [SEL_W-1:0] sel_code_type;

   // strobe commands, selector = {ca2, ca1, ca0, sel}
   localparam sel_code_type CMD_DIR_INWARD  = 4'h0;
   localparam sel_code_type CMD_DIR_OUTWARD = 4'h8;
   localparam sel_code_type CMD_MOTOR_ON    = 4'h4;
   localparam sel_code_type CMD_MOTOR_OFF   = 4'hC;
   localparam sel_code_type CMD_STEP        = 4'h2;
   localparam sel_code_type CMD_CLEAR_NEW   = 4'h9;
   localparam sel_code_type CMD_EJECT       = 4'hE;

   // sense selections
   localparam sel_code_type SNS_DIRECTION   = 4'h0;
   localparam sel_code_type SNS_NO_DISK     = 4'h1;
   localparam sel_code_type SNS_STEP_DONE   = 4'h2;
   localparam sel_code_type SNS_WRITE_EN    = 4'h3;
   localparam sel_code_type SNS_MOTOR_OFF   = 4'h4;
   localparam sel_code_type SNS_NOT_TRACK0  = 4'h5;
   localparam sel_code_type SNS_NOT_NEW     = 4'h6;
   localparam sel_code_type SNS_TACHO       = 4'h7;
   localparam sel_code_type SNS_LOWER_HEAD  = 4'h8;
   localparam sel_code_type SNS_UPPER_HEAD  = 4'h9;
   localparam sel_code_type SNS_SIDES       = 4'hC;

   // input item, last field in the low bits
   typedef struct packed {
      logic               tacho_level;
      logic               write_protected;
      logic               disk_present;
      logic               drive_enabled;
      logic [LINES_W-1:0] control_lines;
   } req_item_type;

   // result item, last field in the low bits
   typedef struct packed {
      logic               eject_pulse;
      logic [ZONE_W-1:0]  speed_zone;
      logic [TRACK_W-1:0] track_now;
      logic               motor_running;
      logic               upper_head;
      logic               sense_bit;
   } rsp_item_type;

   localparam int REQ_ITEM_W = $bits(req_item_type);
   localparam int RSP_ITEM_W = $bits(rsp_item_type);

endpackage

@@ design/fdcs_in_stage.sv @@
// ----------------------------------------------------------------------------
// Floppy drive control sense - input register
// Holds one sampled item until the core hands its result downstream.
// ----------------------------------------------------------------------------
module fdcs_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  fdcs_pkg::req_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output fdcs_pkg::req_item_type out_item
);
   import fdcs_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         load;
   logic         drain;

   // free when empty or when the held item moves on
   assign drain    = valid_ff & out_ready;
   assign in_ready = ~valid_ff | out_ready;
   assign load     = in_valid & in_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ design/fdcs_core.sv @@
// ----------------------------------------------------------------------------
// Floppy drive control sense - drive core
// Drive state, strobe command decode and sense bit selection in one pass.
// ----------------------------------------------------------------------------
module fdcs_core #(
   parameter int MAX_TRACK = 79
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  fdcs_pkg::req_item_type item,
   input  logic                   csr_write,
   input  logic                   csr_value,
   output fdcs_pkg::rsp_item_type result
);
   import fdcs_pkg::*;

   localparam logic [TRACK_W-1:0] TrackLimit = TRACK_W'(MAX_TRACK);

   logic               strobe_before_ff, strobe_before_in;
   logic               disk_before_ff, disk_before_in;
   logic               outward_ff, outward_in;
   logic               motor_ff, motor_in;
   logic [TRACK_W-1:0] track_ff, track_in;
   logic               new_disk_ff, new_disk_in;
   logic               head_ff, head_in;
   logic               double_ff, double_in;

   sel_code_type       sel4;
   logic               strobe_rise;
   logic               motor_cmd;
   logic               eject;
   logic               sense;
   logic [ZONE_W-1:0]  zone_raw;
   logic [ZONE_W-1:0]  zone;

   // selector is {ca2, ca1, ca0, sel}
   assign sel4        = {item.control_lines[2], item.control_lines[1],
                         item.control_lines[0], item.control_lines[3]};
   assign strobe_rise = item.control_lines[4] & ~strobe_before_ff;

   // edge tracking, new-disk detect and strobe command
   always_comb begin
      strobe_before_in = item.control_lines[4];
      disk_before_in   = item.disk_present;
      new_disk_in      = new_disk_ff | (item.disk_present & ~disk_before_ff);
      outward_in       = outward_ff;
      motor_cmd        = motor_ff;
      track_in         = track_ff;
      eject            = 1'b0;
      if (strobe_rise) begin
         case (sel4)
            CMD_DIR_INWARD, CMD_DIR_OUTWARD: begin
               outward_in = sel4[3];
            end
            CMD_MOTOR_ON, CMD_MOTOR_OFF: begin
               motor_cmd = ~sel4[3];
            end
            CMD_STEP: begin
               // clamp at track 0 and at the last track
               if (outward_ff) begin
                  if (track_ff != '0) track_in = track_ff - 1'b1;
               end else begin
                  if (track_ff < TrackLimit) track_in = track_ff + 1'b1;
               end
            end
            CMD_CLEAR_NEW: begin
               new_disk_in = 1'b0;
            end
            CMD_EJECT: begin
               eject = 1'b1;
            end
            default: begin
            end
         endcase
      end
      // deselected drive stops its spindle
      motor_in = motor_cmd & item.drive_enabled;
   end

   // sense bit from updated state; head select happens here too
   always_comb begin
      head_in = head_ff;
      case (sel4)
         SNS_DIRECTION:  sense = outward_in;
         SNS_NO_DISK:    sense = ~item.disk_present;
         SNS_STEP_DONE:  sense = 1'b1;
         SNS_WRITE_EN:   sense = ~item.write_protected;
         SNS_MOTOR_OFF:  sense = ~motor_in;
         SNS_NOT_TRACK0: sense = (track_in != '0);
         SNS_NOT_NEW:    sense = ~new_disk_in;
         SNS_TACHO:      sense = item.tacho_level;
         SNS_LOWER_HEAD: begin
            sense   = 1'b0;
            head_in = 1'b0;
         end
         SNS_UPPER_HEAD: begin
            sense   = 1'b0;
            head_in = double_ff;
         end
         SNS_SIDES:      sense = double_ff;
         default:        sense = 1'b0;
      endcase
   end

   // speed zone: track / 16, capped, only on the zoned drive
   assign zone_raw = track_in[TRACK_W-1:4];
   always_comb begin
      zone = '0;
      if (double_ff) begin
         zone = (zone_raw > ZONE_MAX) ? ZONE_MAX : zone_raw;
      end
   end

   assign double_in = csr_write ? csr_value : double_ff;

   // state registers advance once per item; the double-sided flag follows csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_before_ff <= 1'b0;
         disk_before_ff   <= 1'b0;
         outward_ff       <= 1'b0;
         motor_ff         <= 1'b0;
         track_ff         <= '0;
         new_disk_ff      <= 1'b0;
         head_ff          <= 1'b0;
         double_ff        <= 1'b1;
      end else begin
         double_ff <= double_in;
         if (fire) begin
            strobe_before_ff <= strobe_before_in;
            disk_before_ff   <= disk_before_in;
            outward_ff       <= outward_in;
            motor_ff         <= motor_in;
            track_ff         <= track_in;
            new_disk_ff      <= new_disk_in;
         end
         // single-sided mode forces the lower head
         if (csr_write && !csr_value) begin
            head_ff <= 1'b0;
         end else if (fire) begin
            head_ff <= head_in;
         end
      end
   end

   always_comb begin
      result.sense_bit     = sense;
      result.upper_head    = head_in;
      result.motor_running = motor_in;
      result.track_now     = track_in;
      result.speed_zone    = zone;
      result.eject_pulse   = eject;
   end

endmodule

@@ design/fdcs_out_buf.sv @@
// ----------------------------------------------------------------------------
// Floppy drive control sense - result buffer
// Output register with a skid stage so a stalled result does not stop intake until the skid stage is full.
// ----------------------------------------------------------------------------
module fdcs_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  fdcs_pkg::rsp_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output fdcs_pkg::rsp_item_type out_item
);
   import fdcs_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;
   logic         take;

   assign take     = main_valid_ff & out_ready;
   assign in_ready = ~skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // refill the output from the skid item
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || take) begin
            main_in       = in_item;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_item;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

endmodule

@@ design/floppy_drive_control_sense.sv @@
// ----------------------------------------------------------------------------
// Floppy drive control sense - top level
// Drive side of a 3.5-inch floppy control interface.
// ----------------------------------------------------------------------------
// Takes one sample of the control lines and drive status per clock while
// req_tready is high and gives one result item for each. An accepted item
// is held in the input register, then the single-pass drive core writes its
// result into the result register. Behind the result register sits a one-item
// skid stage, so the input keeps accepting while a result waits; intake stops
// only once both the skid stage and the input register are full. Mode writes
// on the csr channel are always taken and belong between item streams.
`include "floppy_drive_control_sense_macros.svh"

module floppy_drive_control_sense #(
   parameter int MAX_TRACK = 79
) (
   input  logic                             clock,
   input  logic                             reset,
   // bits 4:0 control_lines, 5 drive_enabled, 6 disk_present,
   // 7 write_protected, 8 tacho_level, zero above
   input  logic [fdcs_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // bit 0 sense_bit, 1 upper_head, 2 motor_running, 9:3 track_now,
   // 12:10 speed_zone, 13 eject_pulse, zero above
   output logic [fdcs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_data,
   input  logic                             csr_valid,
   output logic                             csr_ready
);
   import fdcs_pkg::*;

   req_item_type req_item;
   req_item_type core_item;
   rsp_item_type core_rsp;
   rsp_item_type buf_rsp;
   logic         core_valid;
   logic         buf_ready;
   logic         core_fire;
   logic         csr_write;

   assign req_item  = req_item_type'(req_tdata[REQ_ITEM_W-1:0]);
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign core_fire = core_valid & buf_ready;

   // input register
   fdcs_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (core_valid),
      .out_ready (buf_ready),
      .out_item  (core_item)
   );

   // drive state and sense logic
   fdcs_core #(
      .MAX_TRACK (MAX_TRACK)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (core_fire),
      .item      (core_item),
      .csr_write (csr_write),
      .csr_value (csr_data),
      .result    (core_rsp)
   );

   // result register and skid stage
   fdcs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_valid),
      .in_ready  (buf_ready),
      .in_item   (core_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (buf_rsp)
   );

   assign rsp_tdata = RSP_TDATA_W'(buf_rsp);

   // checks
   `FDCS_ASSERT_NOW(a_track_in_range, clock, reset, rsp_tvalid, buf_rsp.track_now <= TRACK_W'(MAX_TRACK))
   `FDCS_ASSERT_NOW(a_eject_needs_strobe, clock, reset, core_fire && core_rsp.eject_pulse, core_item.control_lines[4])
   `FDCS_ASSERT_NEXT(a_stalled_item_held, clock, reset, core_valid && !buf_ready, core_valid && $stable(core_item))

endmodule
